@@ src/assert_macros.svh @@
// Assertion macros shared by the perceptron RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is checked in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication that is checked in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mlp1_pkg.sv @@
// Shared types, command codes and the sigmoid table for the perceptron block.
// No dependencies; the cell, output and top modules import this package.
package mlp1_pkg;

    localparam int SUM_W = 40;
    localparam int VAL_W = 16;

    // Item command codes
    localparam logic [1:0] CMD_HIDDEN_W = 2'd0;
    localparam logic [1:0] CMD_OUT_W    = 2'd1;
    localparam logic [1:0] CMD_FEATURE  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_FEATURE_COUNT = 1'b0;
    localparam logic CFG_HIDDEN_COUNT  = 1'b1;

    localparam logic signed [VAL_W-1:0] NEG_ONE_Q12 = -16'sd4096;
    localparam logic signed [17:0]      NEG_ONE_Q16 = -18'sd65536;

    // Control handed from the sequencer to every cell
    typedef struct packed {
        logic mac;
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef logic [255:0][15:0] sig_table_t;

    // Restoring shift-and-subtract quotient, evaluated while building the table
    function automatic logic [95:0] udiv96(input logic [95:0] n, input logic [95:0] d);
        logic [95:0] q;
        logic [96:0] r;
        q = '0;
        r = '0;
        for (int b = 95; b >= 0; b--)
        begin
            r = {r[95:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Build sigmoid samples at bins -8..+127/16 from powers of e^(-1/16) in Q0.32
    function automatic sig_table_t build_sigmoid();
        logic [95:0] e [0:128];
        logic [95:0] d;
        logic [95:0] s;
        sig_table_t  t;
        e[0] = 96'h1_0000_0000;
        for (int i = 1; i <= 128; i++)
        begin
            e[i] = (e[i-1] * 96'd4034748382 + (96'd1 << 31)) >> 32;
        end
        for (int i = 0; i < 256; i++)
        begin
            if (i >= 128)
            begin
                d = 96'h1_0000_0000 + e[i-128];
                s = udiv96((96'd1 << 48) + (d >> 1), d);
            end
            else
            begin
                d = 96'h1_0000_0000 + e[128-i];
                s = udiv96((e[128-i] << 16) + (d >> 1), d);
            end
            if (s > 96'd65535)
            begin
                s = 96'd65535;
            end
            t[i] = s[15:0];
        end
        return t;
    endfunction

    localparam sig_table_t SIGMOID_TABLE = build_sigmoid();

    // Clamp a bin to -128..127 and map it to a table index
    function automatic logic [7:0] sig_index(input logic signed [19:0] b);
        logic [7:0] r;
        if (b < -20'sd128)
        begin
            r = 8'h00;
        end
        else if (b > 20'sd127)
        begin
            r = 8'hFF;
        end
        else
        begin
            r = {~b[7], b[6:0]};
        end
        return r;
    endfunction

endpackage

@@ src/mlp1_cell.sv @@
// One hidden-node cell: its weight row, a multiply stage and its running sum.
// The sum shifts toward cell 0 during the finishing pass. Depends on mlp1_pkg.
`include "assert_macros.svh"

module mlp1_cell #(
    parameter int CELL_IDX = 0,
    parameter int STRIDE   = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mlp1_pkg::cell_ctl_t                 ctl,
    input  logic                                active,
    input  logic [$clog2(STRIDE)-1:0]           col,
    input  logic signed [mlp1_pkg::VAL_W-1:0]   feat,
    input  logic                                wr_en,
    input  logic [8:0]                          wr_index,
    input  logic signed [mlp1_pkg::VAL_W-1:0]   wr_data,
    input  logic signed [mlp1_pkg::SUM_W-1:0]   shift_in,
    output logic signed [mlp1_pkg::SUM_W-1:0]   sum
);
    import mlp1_pkg::*;

    localparam int COL_W    = $clog2(STRIDE);
    localparam int ROW_BASE = CELL_IDX * STRIDE;

    logic signed [VAL_W-1:0]   wmem [STRIDE];
    logic [31:0]               idx_ext;
    logic [31:0]               idx_off;
    logic                      hit;
    logic [COL_W-1:0]          wcol;
    logic signed [VAL_W-1:0]   w_rd_reg;
    logic signed [VAL_W-1:0]   f1_reg;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;

    // Decode a weight write into this row
    assign idx_ext = 32'(wr_index);
    assign idx_off = idx_ext - 32'(ROW_BASE);
    assign hit     = wr_en && (idx_ext >= 32'(ROW_BASE)) && (idx_off < 32'(STRIDE));
    assign wcol    = idx_off[COL_W-1:0];

    // Hold the row and the multiply data path
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            wmem[wcol] <= wr_data;
        end
        w_rd_reg <= wmem[col];
        f1_reg   <= feat;
        prod_reg <= w_rd_reg * f1_reg;
    end

    // Pick the next sum: clear, shift from the neighbor, or accumulate
    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.clear)
        begin
            sum_next = '0;
        end
        else if (ctl.shift)
        begin
            sum_next = shift_in;
        end
        else if (v2_reg)
        begin
            sum_next = sum_reg + SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            sum_reg <= '0;
        end
        else
        begin
            v1_reg  <= ctl.mac && active;
            v2_reg  <= v1_reg;
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

    `ASSERT_NEXT(a_clear_zeroes_sum, ctl.clear, sum_reg == '0, "cell sum not cleared")

endmodule

@@ src/mlp1_out.sv @@
// Output node: output weights, sigmoid of each streamed hidden sum, weighted
// accumulation and the final sigmoid. Depends on mlp1_pkg.
module mlp1_out #(
    parameter int MAX_HIDDEN = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               ow_we,
    input  logic [8:0]                         ow_index,
    input  logic signed [mlp1_pkg::VAL_W-1:0]  ow_data,
    input  logic                               in_valid,
    input  logic                               in_bias,
    input  logic [$clog2(MAX_HIDDEN+1)-1:0]    in_k,
    input  logic signed [mlp1_pkg::SUM_W-1:0]  in_sum,
    input  logic                               final_go,
    output logic [15:0]                        prediction,
    output logic                               done
);
    import mlp1_pkg::*;

    localparam int K_W      = $clog2(MAX_HIDDEN + 1);
    localparam int OW_DEPTH = MAX_HIDDEN + 1;

    logic signed [VAL_W-1:0] ow_mem [OW_DEPTH];
    logic                    ow_hit;
    logic [15:0]             lut1_reg;
    logic signed [VAL_W-1:0] w1_reg;
    logic                    b1_reg;
    logic                    v1_reg;
    logic signed [17:0]      x1;
    logic signed [33:0]      prod_reg;
    logic                    v2_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic [15:0]             pred_reg;
    logic                    done_reg;

    assign ow_hit = ow_we && (32'(ow_index) < 32'(OW_DEPTH));

    // Select the hidden value, or -1.0 for the bias node
    assign x1 = b1_reg ? NEG_ONE_Q16 : $signed({2'b00, lut1_reg});

    // Hold the weights, the lookup stage, the multiply stage and the final lookup
    always_ff @(posedge clk)
    begin
        if (ow_hit)
        begin
            ow_mem[ow_index[K_W-1:0]] <= ow_data;
        end
        lut1_reg <= SIGMOID_TABLE[sig_index($signed(in_sum[SUM_W-1:20]))];
        w1_reg   <= ow_mem[in_k];
        b1_reg   <= in_bias;
        prod_reg <= w1_reg * x1;
        pred_reg <= SIGMOID_TABLE[sig_index(20'($signed(acc_reg[SUM_W-1:24])))];
    end

    // Accumulate products; the final lookup restarts the sum
    always_comb
    begin
        acc_next = acc_reg;
        if (final_go)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            acc_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            acc_reg  <= acc_next;
            done_reg <= final_go;
        end
    end

    assign prediction = pred_reg;
    assign done       = done_reg;

endmodule

@@ src/mlp_one_hidden_layer_inference_unit.sv @@
// A feature item without last_feature is taken while busy stays low. A last
// feature item starts the finishing pass: busy goes high, and the result comes
// with done high once busy has dropped again. The cell chain shifts one hidden
// sum per cycle into the output node. Results cannot be stalled.
// Reset clears counters, sums and control flags and sets both count registers.
// Depends on mlp1_pkg, mlp1_cell and mlp1_out.
`include "assert_macros.svh"

module mlp_one_hidden_layer_inference_unit #(
    parameter int MAX_FEATURES = 16,
    parameter int MAX_HIDDEN   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         command,
    input  logic [8:0]                         weight_index,
    input  logic signed [mlp1_pkg::VAL_W-1:0]  weight_value,
    input  logic signed [mlp1_pkg::VAL_W-1:0]  feature_value,
    input  logic                               last_feature,
    input  logic                               cfg_we,
    input  logic                               cfg_addr,
    input  logic [4:0]                         cfg_wdata,
    output logic                               done,
    output logic [15:0]                        prediction,
    output logic                               count_error
);
    import mlp1_pkg::*;

    localparam int STRIDE   = MAX_FEATURES + 1;
    localparam int COL_W    = $clog2(STRIDE);
    localparam int CNT_W    = $clog2(MAX_FEATURES + 2);
    localparam int HC_W     = $clog2(MAX_HIDDEN + 1);
    localparam int HC_RESET = (2 > MAX_HIDDEN) ? MAX_HIDDEN : 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_SETTLE,
        ST_SHIFT,
        ST_DRAIN,
        ST_FINAL
    } state_t;

    state_t                  state_reg;
    cell_ctl_t               op_reg;
    logic [COL_W-1:0]        col_reg;
    logic signed [VAL_W-1:0] feat_reg;
    logic                    sv_reg;
    logic                    sb_reg;
    logic [HC_W-1:0]         k_reg;
    logic [1:0]              wait_reg;
    logic                    final_reg;
    logic [CNT_W-1:0]        fs_reg;
    logic [CNT_W-1:0]        fs_next;
    logic                    err_reg;
    logic [CNT_W-1:0]        fc_reg;
    logic [HC_W-1:0]         hc_reg;
    logic                    accept;
    logic                    hw_we;
    logic                    ow_we;
    logic signed [SUM_W-1:0] sums [MAX_HIDDEN+1];

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign hw_we   = accept && (command == CMD_HIDDEN_W);
    assign ow_we   = accept && (command == CMD_OUT_W);
    assign fs_next = (32'(fs_reg) < STRIDE) ? fs_reg + CNT_W'(1) : fs_reg;

    // Clamp register writes to 1..MAX
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= CNT_W'(1);
            hc_reg <= HC_W'(HC_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_FEATURE_COUNT:
                begin
                    if (cfg_wdata == 5'd0)
                        fc_reg <= CNT_W'(1);
                    else if (32'(cfg_wdata) > MAX_FEATURES)
                        fc_reg <= CNT_W'(MAX_FEATURES);
                    else
                        fc_reg <= CNT_W'(cfg_wdata);
                end
                CFG_HIDDEN_COUNT:
                begin
                    if (cfg_wdata == 5'd0)
                        hc_reg <= HC_W'(1);
                    else if (32'(cfg_wdata) > MAX_HIDDEN)
                        hc_reg <= HC_W'(MAX_HIDDEN);
                    else
                        hc_reg <= HC_W'(cfg_wdata);
                end
                default:
                begin
                    fc_reg <= fc_reg;
                end
            endcase
        end
    end

    // Sequence feature items, the bias pass, the shift-out and the final lookup
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
            col_reg   <= '0;
            feat_reg  <= '0;
            sv_reg    <= 1'b0;
            sb_reg    <= 1'b0;
            k_reg     <= '0;
            wait_reg  <= '0;
            final_reg <= 1'b0;
            fs_reg    <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            op_reg    <= '0;
            sv_reg    <= 1'b0;
            sb_reg    <= 1'b0;
            final_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (command == CMD_FEATURE))
                    begin
                        op_reg.mac <= (fs_reg < fc_reg);
                        col_reg    <= fs_reg[COL_W-1:0];
                        feat_reg   <= feature_value;
                        if (last_feature)
                        begin
                            fs_reg    <= '0;
                            err_reg   <= (fs_next != fc_reg);
                            state_reg <= ST_BIAS;
                        end
                        else
                        begin
                            fs_reg <= fs_next;
                        end
                    end
                end
                ST_BIAS:
                begin
                    op_reg.mac <= 1'b1;
                    col_reg    <= fc_reg[COL_W-1:0];
                    feat_reg   <= NEG_ONE_Q12;
                    wait_reg   <= 2'd2;
                    state_reg  <= ST_SETTLE;
                end
                ST_SETTLE:
                begin
                    if (wait_reg == 2'd0)
                    begin
                        op_reg.shift <= 1'b1;
                        sv_reg       <= 1'b1;
                        k_reg        <= '0;
                        state_reg    <= ST_SHIFT;
                    end
                    else
                    begin
                        wait_reg <= wait_reg - 2'd1;
                    end
                end
                ST_SHIFT:
                begin
                    // After the last hidden node, stream the bias node
                    if (k_reg == hc_reg - HC_W'(1))
                    begin
                        sv_reg    <= 1'b1;
                        sb_reg    <= 1'b1;
                        k_reg     <= hc_reg;
                        wait_reg  <= 2'd2;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        op_reg.shift <= 1'b1;
                        sv_reg       <= 1'b1;
                        k_reg        <= k_reg + HC_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (wait_reg == 2'd0)
                    begin
                        final_reg <= 1'b1;
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        wait_reg <= wait_reg - 2'd1;
                    end
                end
                ST_FINAL:
                begin
                    op_reg.clear <= 1'b1;
                    state_reg    <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Row of hidden cells; the top cell shifts in zero
    assign sums[MAX_HIDDEN] = '0;

    for (genvar h = 0; h < MAX_HIDDEN; h++)
    begin : g_cell
        mlp1_cell #(
            .CELL_IDX (h),
            .STRIDE   (STRIDE)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (op_reg),
            .active   (32'(h) < 32'(hc_reg)),
            .col      (col_reg),
            .feat     (feat_reg),
            .wr_en    (hw_we),
            .wr_index (weight_index),
            .wr_data  (weight_value),
            .shift_in (sums[h+1]),
            .sum      (sums[h])
        );
    end

    mlp1_out #(
        .MAX_HIDDEN (MAX_HIDDEN)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .ow_we      (ow_we),
        .ow_index   (weight_index),
        .ow_data    (weight_value),
        .in_valid   (sv_reg),
        .in_bias    (sb_reg),
        .in_k       (k_reg),
        .in_sum     (sums[0]),
        .final_go   (final_reg),
        .prediction (prediction),
        .done       (done)
    );

    assign count_error = err_reg;

    `ASSERT_SAME(a_done_when_idle, done, !busy, "result while busy")
    `ASSERT_SAME(a_done_clears_cells, done, op_reg.clear, "cells not cleared with result")
    `ASSERT_NEXT(a_last_goes_busy, accept && (command == CMD_FEATURE) && last_feature, busy,
        "last feature did not start finishing pass")

endmodule
